### src/nnsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnsa_pkg
// Shared types, widths and helpers of the nearest-neighbour scale addresser.
// ----------------------------------------------------------------------------
package nnsa_pkg;

  localparam int unsigned MaxDim     = 4096;
  localparam int unsigned MaxStride  = 16384;
  localparam int unsigned MaxBytes   = 4;

  localparam int unsigned CoordW     = 12;
  localparam int unsigned DimW       = 13;
  localparam int unsigned BytesW     = 3;
  localparam int unsigned StrideW    = 15;
  localparam int unsigned OffW       = 26;
  localparam int unsigned NumW       = 24;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 15;
  localparam int unsigned DivSteps   = 12;
  localparam int unsigned StepW      = 4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3,
    REG_SRC_BYTES  = 3'd4,
    REG_DST_BYTES  = 3'd5,
    REG_SRC_STRIDE = 3'd6,
    REG_DST_STRIDE = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_X,
    ST_DIV_X,
    ST_LOAD_Y,
    ST_DIV_Y,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic latch;
    logic load_x;
    logic load_y;
    logic step;
    logic finish;
  } cmd_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) r = DimW'(1);
    else if (v > DimW'(MaxDim)) r = DimW'(MaxDim);
    return r;
  endfunction

  function automatic logic [BytesW-1:0] clamp_bytes(input logic [BytesW-1:0] v);
    logic [BytesW-1:0] r;
    r = v;
    if (v == '0) r = BytesW'(1);
    else if (v > BytesW'(MaxBytes)) r = BytesW'(MaxBytes);
    return r;
  endfunction

  function automatic logic [StrideW-1:0] clamp_stride(input logic [StrideW-1:0] v);
    return (v > StrideW'(MaxStride)) ? StrideW'(MaxStride) : v;
  endfunction

endpackage

### src/nnsa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnsa_ctrl
// Sequencer: input handshake, divider step count and output valid.
// ----------------------------------------------------------------------------
module nnsa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output nnsa_pkg::cmd_t     cmd_o
);

  nnsa_pkg::state_e                 state_q, state_d;
  logic [nnsa_pkg::StepW-1:0]       step_q, step_d;
  logic                             out_valid_q, out_valid_d;
  logic                             last_step;
  logic                             out_busy;

  assign last_step  = (step_q == nnsa_pkg::StepW'(nnsa_pkg::DivSteps - 1));
  assign out_busy   = out_valid_q && out_stall_i;
  assign in_stall_o = (state_q != nnsa_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nnsa_pkg::ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    unique case (state_q)
      nnsa_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = nnsa_pkg::ST_LOAD_X;
        end
      end
      nnsa_pkg::ST_LOAD_X: begin
        cmd_o.load_x = 1'b1;
        step_d       = '0;
        state_d      = nnsa_pkg::ST_DIV_X;
      end
      nnsa_pkg::ST_DIV_X: begin
        cmd_o.step = 1'b1;
        step_d     = step_q + 1'b1;
        if (last_step) state_d = nnsa_pkg::ST_LOAD_Y;
      end
      nnsa_pkg::ST_LOAD_Y: begin
        cmd_o.load_y = 1'b1;
        step_d       = '0;
        state_d      = nnsa_pkg::ST_DIV_Y;
      end
      nnsa_pkg::ST_DIV_Y: begin
        cmd_o.step = 1'b1;
        step_d     = step_q + 1'b1;
        if (last_step) state_d = nnsa_pkg::ST_FINISH;
      end
      nnsa_pkg::ST_FINISH: begin
        if (!out_busy) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = nnsa_pkg::ST_IDLE;
        end
      end
      default: state_d = nnsa_pkg::ST_IDLE;
    endcase
  end

endmodule

### src/nnsa_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnsa_datapath
// Configuration registers, raster position, shared divider and offset stage.
// ----------------------------------------------------------------------------
module nnsa_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [nnsa_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [nnsa_pkg::CfgDataW-1:0]    cfg_data_i,
  input  nnsa_pkg::cmd_t                   cmd_i,
  input  logic                             restart_i,
  output logic [nnsa_pkg::OffW-1:0]        src_offset_o,
  output logic [nnsa_pkg::OffW-1:0]        dst_offset_o,
  output logic                             end_of_line_o,
  output logic                             end_of_frame_o,
  output logic                             format_error_o
);

  localparam int unsigned CW = nnsa_pkg::CoordW;
  localparam int unsigned DW = nnsa_pkg::DimW;
  localparam int unsigned BW = nnsa_pkg::BytesW;
  localparam int unsigned SW = nnsa_pkg::StrideW;
  localparam int unsigned OW = nnsa_pkg::OffW;
  localparam int unsigned NW = nnsa_pkg::NumW;

  logic [DW-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
  logic [BW-1:0] src_b_q, dst_b_q;
  logic [SW-1:0] src_s_q, dst_s_q;

  logic [DW-1:0] sw, sh, dw, dh;
  logic [BW-1:0] pb;
  logic [SW-1:0] ss, ds;
  logic          err;

  logic [CW-1:0] cur_col_q, cur_row_q;
  logic [CW-1:0] x_q, y_q;
  logic [CW-1:0] x_d, y_d;

  logic [CW-1:0] rem_q;
  logic [CW-1:0] quo_q;
  logic [CW-1:0] sx_q;
  logic [DW-1:0] divisor_q;

  logic [DW+CW-1:0] prod;
  logic [NW-1:0]    num;
  logic [DW-1:0]    trial;
  logic             ge;
  logic [DW-1:0]    diff;

  logic             eol, eof;
  logic [CW+SW:0]   src_sum, dst_sum;

  logic [OW-1:0]    src_off_q, dst_off_q;
  logic             eol_q, eof_q, err_q;

  assign sw  = nnsa_pkg::clamp_dim(src_w_q);
  assign sh  = nnsa_pkg::clamp_dim(src_h_q);
  assign dw  = nnsa_pkg::clamp_dim(dst_w_q);
  assign dh  = nnsa_pkg::clamp_dim(dst_h_q);
  assign pb  = nnsa_pkg::clamp_bytes(src_b_q);
  assign ss  = nnsa_pkg::clamp_stride(src_s_q);
  assign ds  = nnsa_pkg::clamp_stride(dst_s_q);
  assign err = (src_b_q != dst_b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= DW'(1);
      src_h_q <= DW'(1);
      dst_w_q <= DW'(1);
      dst_h_q <= DW'(1);
      src_b_q <= BW'(2);
      dst_b_q <= BW'(2);
      src_s_q <= SW'(2);
      dst_s_q <= SW'(2);
    end else if (cfg_we_i) begin
      unique case (nnsa_pkg::cfg_reg_e'(cfg_index_i))
        nnsa_pkg::REG_SRC_WIDTH:  src_w_q <= cfg_data_i[DW-1:0];
        nnsa_pkg::REG_SRC_HEIGHT: src_h_q <= cfg_data_i[DW-1:0];
        nnsa_pkg::REG_DST_WIDTH:  dst_w_q <= cfg_data_i[DW-1:0];
        nnsa_pkg::REG_DST_HEIGHT: dst_h_q <= cfg_data_i[DW-1:0];
        nnsa_pkg::REG_SRC_BYTES:  src_b_q <= cfg_data_i[BW-1:0];
        nnsa_pkg::REG_DST_BYTES:  dst_b_q <= cfg_data_i[BW-1:0];
        nnsa_pkg::REG_SRC_STRIDE: src_s_q <= cfg_data_i[SW-1:0];
        nnsa_pkg::REG_DST_STRIDE: dst_s_q <= cfg_data_i[SW-1:0];
        default: ;
      endcase
    end
  end

  // pick the pixel for this beat: restart or fold back into the frame
  always_comb begin
    x_d = cur_col_q;
    y_d = cur_row_q;
    if (restart_i) begin
      x_d = '0;
      y_d = '0;
    end else begin
      if ({1'b0, cur_col_q} >= dw) x_d = '0;
      if ({1'b0, cur_row_q} >= dh) y_d = '0;
    end
  end

  // numerator and restoring divider step
  assign prod  = cmd_i.load_y ? (y_q * sh) : (x_q * sw);
  assign num   = prod[NW-1:0];
  assign trial = {rem_q, quo_q[CW-1]};
  assign ge    = (trial >= divisor_q);
  assign diff  = trial - divisor_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      x_q <= x_d;
      y_q <= y_d;
    end
    if (cmd_i.load_x || cmd_i.load_y) begin
      rem_q     <= num[NW-1:CW];
      quo_q     <= num[CW-1:0];
      divisor_q <= cmd_i.load_y ? dh : dw;
    end else if (cmd_i.step) begin
      rem_q <= ge ? diff[CW-1:0] : trial[CW-1:0];
      quo_q <= {quo_q[CW-2:0], ge};
    end
    if (cmd_i.load_y) sx_q <= quo_q;
  end

  assign eol     = (({1'b0, x_q} + DW'(1)) == dw);
  assign eof     = eol && (({1'b0, y_q} + DW'(1)) == dh);
  assign src_sum = (CW+SW+1)'(quo_q * ss) + (CW+SW+1)'(sx_q * pb);
  assign dst_sum = (CW+SW+1)'(y_q * ds) + (CW+SW+1)'(x_q * pb);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q <= '0;
      cur_row_q <= '0;
    end else if (cmd_i.finish) begin
      if (eol) begin
        cur_col_q <= '0;
        cur_row_q <= eof ? '0 : y_q + 1'b1;
      end else begin
        cur_col_q <= x_q + 1'b1;
        cur_row_q <= y_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      src_off_q <= err ? '0 : src_sum[OW-1:0];
      dst_off_q <= err ? '0 : dst_sum[OW-1:0];
      eol_q     <= eol;
      eof_q     <= eof;
      err_q     <= err;
    end
  end

  assign src_offset_o   = src_off_q;
  assign dst_offset_o   = dst_off_q;
  assign end_of_line_o  = eol_q;
  assign end_of_frame_o = eof_q;
  assign format_error_o = err_q;

endmodule

### src/nearest_neighbour_scale_addresser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbour_scale_addresser_core
// Walks the destination raster and gives source and destination byte offsets.
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// in       sink       in_valid_i/in_stall_o   restart_i
// out      source     out_valid_o/out_stall_i src/dst offsets, eol, eof, error
// cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Each beat is taken in idle and runs through the load and finish states and two
// 12-step passes of the shared restoring divider; a new beat is taken only once
// the sequencer is back in idle, and in_stall_o is high until then.
// Reset restores the register defaults and restarts the walk at pixel (0,0).
// A result held by out_stall_i does not block the next input beat; that beat
// waits in the finish cycle until the output register is free.
// ----------------------------------------------------------------------------
module nearest_neighbour_scale_addresser_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            restart_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [nnsa_pkg::OffW-1:0]       src_offset_o,
  output logic [nnsa_pkg::OffW-1:0]       dst_offset_o,
  output logic                            end_of_line_o,
  output logic                            end_of_frame_o,
  output logic                            format_error_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [nnsa_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [nnsa_pkg::CfgDataW-1:0]   cfg_data_i
);

  nnsa_pkg::cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  nnsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  nnsa_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i & cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .restart_i      (restart_i),
    .src_offset_o   (src_offset_o),
    .dst_offset_o   (dst_offset_o),
    .end_of_line_o  (end_of_line_o),
    .end_of_frame_o (end_of_frame_o),
    .format_error_o (format_error_o)
  );

endmodule
